// File: hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hw/rtl/drfr_pkg.sv
// ----------------------------------------------------------------------------
// drfr_pkg
// types, constants and helpers of the dead reckoning fix realigner
// ----------------------------------------------------------------------------
package drfr_pkg;

   localparam int POS_W   = 40;
   localparam int STAMP_W = 48;
   localparam int VEL_W   = 32;
   localparam int DT_W    = 49;
   localparam int PROD_W  = 56;
   localparam int MAG_W   = 42;
   localparam int DIFF_W  = 41;
   localparam int WIDE_W  = 44;
   localparam int NUM_AXES = 3;

   localparam logic [MAG_W-1:0] MAG_LIMIT = 42'h200_0000_0000;
   localparam logic signed [WIDE_W-1:0] WIDE_MAX = 44'sh0_7F_FFFF_FFFF;
   localparam logic signed [WIDE_W-1:0] WIDE_MIN = -44'sh0_80_0000_0000;

   typedef logic signed [POS_W-1:0] pos_type;

   typedef struct packed {
      logic                      func;
      logic [STAMP_W-1:0]        stamp;
      logic signed [VEL_W-1:0]   vel_east;
      logic signed [VEL_W-1:0]   vel_north;
      logic signed [VEL_W-1:0]   vel_up;
      logic signed [POS_W-1:0]   fix_east;
      logic signed [POS_W-1:0]   fix_north;
      logic signed [POS_W-1:0]   fix_up;
   } req_type;

   typedef struct packed {
      logic [STAMP_W-1:0]        out_stamp;
      logic signed [POS_W-1:0]   pos_east;
      logic signed [POS_W-1:0]   pos_north;
      logic signed [POS_W-1:0]   pos_up;
      logic                      enabled;
      logic                      estimated;
      logic                      position_valid;
   } rsp_type;

   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      pos_type            east;
      pos_type            north;
      pos_type            up;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_HI,
      ST_MUL_LO,
      ST_ADD,
      ST_WRITE,
      ST_SRCH,
      ST_REWR,
      ST_DECIDE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic accept_vel;
      logic load_fix;
      logic mul_hi;
      logic mul_lo;
      logic adv_add;
      logic ring_wr;
      logic srch_step;
      logic rewr_step;
      logic decide;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic last_axis;
      logic need_search;
      logic hit;
      logic miss;
      logic can_realign;
      logic rewr_done;
   } sts_type;

   function automatic pos_type sat40(input logic signed [WIDE_W-1:0] v);
      pos_type r;
      if (v > WIDE_MAX) begin
         r = WIDE_MAX[POS_W-1:0];
      end else if (v < WIDE_MIN) begin
         r = WIDE_MIN[POS_W-1:0];
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/drfr_ctrl.sv
// ----------------------------------------------------------------------------
// drfr_ctrl
// sequencer: fix latch, advance, ring write, search, rewrite, decision, result
// ----------------------------------------------------------------------------
module drfr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               func,
   input  drfr_pkg::sts_type  sts,
   output drfr_pkg::cmd_type  cmd,
   output logic               busy
);

   drfr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= drfr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != drfr_pkg::ST_IDLE);
      unique case (state_ff)
         drfr_pkg::ST_IDLE: begin
            if (start && func) begin
               cmd.load_fix = 1'b1;
            end else if (start) begin
               cmd.accept_vel = 1'b1;
               state_in = drfr_pkg::ST_MUL_HI;
            end
         end
         drfr_pkg::ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in = drfr_pkg::ST_MUL_LO;
         end
         drfr_pkg::ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in = drfr_pkg::ST_ADD;
         end
         drfr_pkg::ST_ADD: begin
            cmd.adv_add = 1'b1;
            state_in = sts.last_axis ? drfr_pkg::ST_WRITE : drfr_pkg::ST_MUL_HI;
         end
         drfr_pkg::ST_WRITE: begin
            cmd.ring_wr = 1'b1;
            state_in = sts.need_search ? drfr_pkg::ST_SRCH : drfr_pkg::ST_DECIDE;
         end
         drfr_pkg::ST_SRCH: begin
            cmd.srch_step = 1'b1;
            priority if (sts.hit) begin
               state_in = sts.can_realign ? drfr_pkg::ST_REWR : drfr_pkg::ST_DECIDE;
            end else if (sts.miss) begin
               state_in = drfr_pkg::ST_DECIDE;
            end else begin
               state_in = drfr_pkg::ST_SRCH;
            end
         end
         drfr_pkg::ST_REWR: begin
            cmd.rewr_step = 1'b1;
            if (sts.rewr_done) begin
               state_in = drfr_pkg::ST_DECIDE;
            end
         end
         drfr_pkg::ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in = drfr_pkg::ST_RESP;
         end
         drfr_pkg::ST_RESP: begin
            cmd.respond = 1'b1;
            state_in = drfr_pkg::ST_IDLE;
         end
         default: begin
            state_in = drfr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: hw/rtl/drfr_dp.sv
// ----------------------------------------------------------------------------
// drfr_dp
// datapath: fix latch, shared multiplier, history ring and result register
// ----------------------------------------------------------------------------
module drfr_dp #(
   parameter int RING_DEPTH = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  drfr_pkg::req_type  req_item,
   input  drfr_pkg::cmd_type  cmd,
   output drfr_pkg::sts_type  sts,
   output logic               rsp_strobe,
   output drfr_pkg::rsp_type  rsp_item
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam int FW = $clog2(RING_DEPTH + 1);
   localparam logic [AW-1:0] SLOT_LAST = AW'(RING_DEPTH - 1);
   localparam logic [FW-1:0] FILL_MAX  = FW'(RING_DEPTH);

   // history ring
   drfr_pkg::entry_type mem [RING_DEPTH];
   drfr_pkg::entry_type rd_ff;
   logic                we;
   logic [AW-1:0]       waddr;
   drfr_pkg::entry_type wdata;

   // fix and item state
   logic [drfr_pkg::STAMP_W-1:0] fix_stamp_ff, fix_stamp_in;
   logic [drfr_pkg::STAMP_W-1:0] prev_fix_ff, prev_fix_in;
   logic [drfr_pkg::STAMP_W-1:0] last_stamp_ff, last_stamp_in;
   logic [drfr_pkg::STAMP_W-1:0] cur_stamp_ff, cur_stamp_in;
   drfr_pkg::pos_type            fix_pos_ff [drfr_pkg::NUM_AXES];
   drfr_pkg::pos_type            fix_pos_in [drfr_pkg::NUM_AXES];
   logic signed [drfr_pkg::VEL_W-1:0] vel_ff [drfr_pkg::NUM_AXES];
   logic signed [drfr_pkg::VEL_W-1:0] vel_in [drfr_pkg::NUM_AXES];
   drfr_pkg::pos_type            prov_ff [drfr_pkg::NUM_AXES];
   drfr_pkg::pos_type            prov_in [drfr_pkg::NUM_AXES];
   drfr_pkg::pos_type            outp_ff [drfr_pkg::NUM_AXES];
   drfr_pkg::pos_type            outp_in [drfr_pkg::NUM_AXES];
   logic signed [drfr_pkg::DIFF_W-1:0] d_ff [drfr_pkg::NUM_AXES];
   logic signed [drfr_pkg::DIFF_W-1:0] d_in [drfr_pkg::NUM_AXES];

   // advance
   logic [drfr_pkg::STAMP_W-1:0] md_ff, md_in;
   logic                         dt_neg_ff, dt_neg_in;
   logic                         nz_ff, nz_in;
   logic [1:0]                   axis_ff, axis_in;
   logic [drfr_pkg::PROD_W-1:0]  prod_a_ff, prod_a_in;
   logic [drfr_pkg::PROD_W-1:0]  prod_b_ff, prod_b_in;

   // counters and flags
   logic [1:0]    fixes_ff, fixes_in;
   logic [1:0]    samples_ff, samples_in;
   logic          started_ff, started_in;
   logic          fresh_ff, fresh_in;
   logic          en_ff, en_in;
   logic          est_ff, est_in;
   logic          realigned_ff, realigned_in;
   logic [AW-1:0] head_ff, head_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [AW-1:0] newest_ff, newest_in;
   logic [AW-1:0] rd_slot_ff, rd_slot_in;
   logic [FW-1:0] issue_left_ff, issue_left_in;
   logic          cmp_valid_ff, cmp_valid_in;
   logic [AW-1:0] cmp_slot_ff, cmp_slot_in;
   logic          rewr_issue_ff, rewr_issue_in;

   logic              rsp_strobe_ff, rsp_strobe_in;
   drfr_pkg::rsp_type rsp_item_ff, rsp_item_in;

   logic hit;

   assign hit = cmp_valid_ff && (rd_ff.stamp == fix_stamp_ff);

   always_comb begin
      sts.last_axis   = (axis_ff == 2'd2);
      sts.need_search = started_ff && fresh_ff;
      sts.hit         = hit;
      sts.miss        = !cmp_valid_ff && (issue_left_ff == '0);
      sts.can_realign = (fixes_ff == 2'd2);
      sts.rewr_done   = cmp_valid_ff && (cmp_slot_ff == newest_ff);
   end

   always_comb begin
      logic signed [drfr_pkg::DT_W-1:0]   dt;
      logic signed [drfr_pkg::VEL_W-1:0]  vsel;
      logic [drfr_pkg::VEL_W-1:0]         mv;
      logic                               neg;
      logic                               a_big;
      logic [drfr_pkg::DT_W-1:0]          sum;
      logic [drfr_pkg::MAG_W-1:0]         mag;
      logic signed [drfr_pkg::WIDE_W-1:0] base;
      logic signed [drfr_pkg::WIDE_W-1:0] magw;
      drfr_pkg::pos_type                  fixd [drfr_pkg::NUM_AXES];
      drfr_pkg::pos_type                  rdp [drfr_pkg::NUM_AXES];

      fix_stamp_in  = fix_stamp_ff;
      prev_fix_in   = prev_fix_ff;
      last_stamp_in = last_stamp_ff;
      cur_stamp_in  = cur_stamp_ff;
      fix_pos_in    = fix_pos_ff;
      vel_in        = vel_ff;
      prov_in       = prov_ff;
      outp_in       = outp_ff;
      d_in          = d_ff;
      md_in         = md_ff;
      dt_neg_in     = dt_neg_ff;
      nz_in         = nz_ff;
      axis_in       = axis_ff;
      prod_a_in     = prod_a_ff;
      prod_b_in     = prod_b_ff;
      fixes_in      = fixes_ff;
      samples_in    = samples_ff;
      started_in    = started_ff;
      fresh_in      = fresh_ff;
      en_in         = en_ff;
      est_in        = est_ff;
      realigned_in  = realigned_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      newest_in     = newest_ff;
      rd_slot_in    = rd_slot_ff;
      issue_left_in = issue_left_ff;
      cmp_valid_in  = cmp_valid_ff;
      cmp_slot_in   = cmp_slot_ff;
      rewr_issue_in = rewr_issue_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      we            = 1'b0;
      waddr         = head_ff;
      wdata         = rd_ff;

      dt = $signed({1'b0, req_item.stamp}) - $signed({1'b0, last_stamp_ff});

      vsel = vel_ff[axis_ff];
      mv   = vsel[drfr_pkg::VEL_W-1] ? drfr_pkg::VEL_W'(-vsel) : drfr_pkg::VEL_W'(vsel);
      neg  = vsel[drfr_pkg::VEL_W-1] ^ dt_neg_ff;

      // magnitude of vel*dt >> 16, clamped just past the 40 bit range
      a_big = |prod_a_ff[drfr_pkg::PROD_W-1:40];
      sum   = {1'b0, prod_a_ff[39:0], 8'b0} + drfr_pkg::DT_W'(prod_a_ff[0] & 1'b0)
            + drfr_pkg::DT_W'(prod_b_ff[drfr_pkg::PROD_W-1:16]);
      mag   = (a_big || (sum > drfr_pkg::DT_W'(drfr_pkg::MAG_LIMIT)))
              ? drfr_pkg::MAG_LIMIT : sum[drfr_pkg::MAG_W-1:0];
      base  = {{4{outp_ff[axis_ff][drfr_pkg::POS_W-1]}}, outp_ff[axis_ff]};
      magw  = {2'b00, mag};

      rdp[0] = rd_ff.east;
      rdp[1] = rd_ff.north;
      rdp[2] = rd_ff.up;
      for (int i = 0; i < drfr_pkg::NUM_AXES; i++) begin
         fixd[i] = drfr_pkg::sat40({{4{rdp[i][drfr_pkg::POS_W-1]}}, rdp[i]}
                                   - {{3{d_ff[i][drfr_pkg::DIFF_W-1]}}, d_ff[i]});
      end

      if (cmd.load_fix) begin
         fix_stamp_in  = req_item.stamp;
         fix_pos_in[0] = req_item.fix_east;
         fix_pos_in[1] = req_item.fix_north;
         fix_pos_in[2] = req_item.fix_up;
      end

      if (cmd.accept_vel) begin
         cur_stamp_in  = req_item.stamp;
         vel_in[0]     = req_item.vel_east;
         vel_in[1]     = req_item.vel_north;
         vel_in[2]     = req_item.vel_up;
         dt_neg_in     = dt[drfr_pkg::DT_W-1];
         md_in         = dt[drfr_pkg::DT_W-1] ? drfr_pkg::STAMP_W'(-dt)
                                              : dt[drfr_pkg::STAMP_W-1:0];
         nz_in         = (last_stamp_ff != '0);
         last_stamp_in = req_item.stamp;
         if (samples_ff != 2'd2) begin
            samples_in = samples_ff + 2'd1;
         end
         if (fill_ff != FILL_MAX) begin
            fill_in = fill_ff + 1'b1;
         end
         fresh_in    = (prev_fix_ff != fix_stamp_ff);
         prev_fix_in = fix_stamp_ff;
         if (prev_fix_ff != fix_stamp_ff) begin
            started_in = 1'b1;
            if (fixes_ff != 2'd2) begin
               fixes_in = fixes_ff + 2'd1;
            end
         end
         axis_in      = 2'd0;
         realigned_in = 1'b0;
      end

      if (cmd.mul_hi) begin
         prod_a_in = mv * md_ff[drfr_pkg::STAMP_W-1:24];
      end
      if (cmd.mul_lo) begin
         prod_b_in = mv * md_ff[23:0];
      end
      if (cmd.adv_add) begin
         if (nz_ff) begin
            prov_in[axis_ff] = drfr_pkg::sat40(neg ? base - magw : base + magw);
         end
         axis_in = axis_ff + 2'd1;
      end

      if (cmd.ring_wr) begin
         we            = 1'b1;
         waddr         = head_ff;
         wdata.stamp   = cur_stamp_ff;
         wdata.east    = prov_ff[0];
         wdata.north   = prov_ff[1];
         wdata.up      = prov_ff[2];
         newest_in     = head_ff;
         head_in       = (head_ff == SLOT_LAST) ? '0 : head_ff + 1'b1;
         rd_slot_in    = head_ff;
         issue_left_in = fill_ff;
         cmp_valid_in  = 1'b0;
      end

      if (cmd.srch_step) begin
         priority if (hit) begin
            for (int i = 0; i < drfr_pkg::NUM_AXES; i++) begin
               d_in[i] = {rdp[i][drfr_pkg::POS_W-1], rdp[i]}
                       - {fix_pos_ff[i][drfr_pkg::POS_W-1], fix_pos_ff[i]};
            end
            rd_slot_in    = cmp_slot_ff;
            rewr_issue_in = 1'b1;
            cmp_valid_in  = 1'b0;
         end else if (issue_left_ff != '0) begin
            cmp_valid_in  = 1'b1;
            cmp_slot_in   = rd_slot_ff;
            rd_slot_in    = (rd_slot_ff == '0) ? SLOT_LAST : rd_slot_ff - 1'b1;
            issue_left_in = issue_left_ff - 1'b1;
         end else begin
            cmp_valid_in = 1'b0;
         end
      end

      if (cmd.rewr_step) begin
         if (rewr_issue_ff) begin
            cmp_valid_in = 1'b1;
            cmp_slot_in  = rd_slot_ff;
            if (rd_slot_ff == newest_ff) begin
               rewr_issue_in = 1'b0;
            end else begin
               rd_slot_in = (rd_slot_ff == SLOT_LAST) ? '0 : rd_slot_ff + 1'b1;
            end
         end else begin
            cmp_valid_in = 1'b0;
         end
         if (cmp_valid_ff) begin
            we          = 1'b1;
            waddr       = cmp_slot_ff;
            wdata.stamp = rd_ff.stamp;
            wdata.east  = fixd[0];
            wdata.north = fixd[1];
            wdata.up    = fixd[2];
            if (cmp_slot_ff == newest_ff) begin
               prov_in      = fixd;
               en_in        = 1'b1;
               est_in       = 1'b1;
               realigned_in = 1'b1;
            end
         end
      end

      if (cmd.decide && started_ff && !realigned_ff) begin
         priority if (fixes_ff == 2'd1) begin
            prov_in = fix_pos_ff;
            en_in   = 1'b1;
            est_in  = 1'b0;
         end else if (samples_ff == 2'd2) begin
            est_in = 1'b0;
         end
      end

      if (cmd.respond) begin
         if (fixes_ff == 2'd2) begin
            outp_in = prov_ff;
         end
         rsp_strobe_in              = 1'b1;
         rsp_item_in.out_stamp      = cur_stamp_ff;
         rsp_item_in.pos_east       = outp_in[0];
         rsp_item_in.pos_north      = outp_in[1];
         rsp_item_in.pos_up         = outp_in[2];
         rsp_item_in.enabled        = en_ff;
         rsp_item_in.estimated      = est_ff;
         rsp_item_in.position_valid = (fixes_ff == 2'd2);
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[rd_slot_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fix_stamp_ff  <= '0;
         prev_fix_ff   <= '0;
         last_stamp_ff <= '0;
         fix_pos_ff    <= '{default: '0};
         prov_ff       <= '{default: '0};
         outp_ff       <= '{default: '0};
         fixes_ff      <= '0;
         samples_ff    <= '0;
         started_ff    <= 1'b0;
         fresh_ff      <= 1'b0;
         en_ff         <= 1'b0;
         est_ff        <= 1'b0;
         realigned_ff  <= 1'b0;
         head_ff       <= '0;
         fill_ff       <= '0;
         issue_left_ff <= '0;
         cmp_valid_ff  <= 1'b0;
         rewr_issue_ff <= 1'b0;
         axis_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         fix_stamp_ff  <= fix_stamp_in;
         prev_fix_ff   <= prev_fix_in;
         last_stamp_ff <= last_stamp_in;
         fix_pos_ff    <= fix_pos_in;
         prov_ff       <= prov_in;
         outp_ff       <= outp_in;
         fixes_ff      <= fixes_in;
         samples_ff    <= samples_in;
         started_ff    <= started_in;
         fresh_ff      <= fresh_in;
         en_ff         <= en_in;
         est_ff        <= est_in;
         realigned_ff  <= realigned_in;
         head_ff       <= head_in;
         fill_ff       <= fill_in;
         issue_left_ff <= issue_left_in;
         cmp_valid_ff  <= cmp_valid_in;
         rewr_issue_ff <= rewr_issue_in;
         axis_ff       <= axis_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_stamp_ff <= cur_stamp_in;
      vel_ff       <= vel_in;
      d_ff         <= d_in;
      md_ff        <= md_in;
      dt_neg_ff    <= dt_neg_in;
      nz_ff        <= nz_in;
      prod_a_ff    <= prod_a_in;
      prod_b_ff    <= prod_b_in;
      newest_ff    <= newest_in;
      rd_slot_ff   <= rd_slot_in;
      cmp_slot_ff  <= cmp_slot_in;
      rsp_item_ff  <= rsp_item_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

// File: hw/rtl/dead_reckoning_fix_realigner.sv
// ----------------------------------------------------------------------------
// dead_reckoning_fix_realigner
// dead-reckoned position with realignment of recent history to matched fixes
// ----------------------------------------------------------------------------
// usage
//   an item transfer happens on a rising edge with start high and busy low;
//   req_item.func selects a fix (latched only) or a velocity sample
//   a fix transfer leaves busy low and gives no result
//   a velocity sample gives exactly one result: rsp_strobe is high for one
//   cycle with rsp_item, and the receiver cannot hold it off
//   velocity path: advance (3 axes x hi, lo, add on one shared 32x24
//   multiplier), ring write, search and rewrite when needed, decide, respond
//   search reads one ring entry a cycle, newest first, until a hit or miss
//   rewrite reads and writes one entry a cycle, up to the newest entry
//   busy time is set by the single read port of the history ring;
//   one item is in flight at a time
//   busy stays high for the whole item; the result strobe comes in the
//   first cycle with busy low, when a new transfer may already be taken
//   reset clears the counters, positions and status flags; the ring needs no
//   clearing as only filled entries are ever read
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dead_reckoning_fix_realigner #(
   parameter int RING_DEPTH = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  drfr_pkg::req_type  req_item,
   output logic               rsp_strobe,
   output drfr_pkg::rsp_type  rsp_item
);

   // command and status between sequencer and datapath
   drfr_pkg::cmd_type cmd;
   drfr_pkg::sts_type sts;

   // sequencer
   drfr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .func  (req_item.func),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   // datapath with history ring
   drfr_dp #(
      .RING_DEPTH (RING_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // a result only ever follows a velocity item in progress
   `ASSERT_IMPLY(a_rsp_after_work, clock, reset, rsp_strobe, $past(busy))
   // one strobe per item
   `ASSERT_NEXT(a_rsp_single, clock, reset, rsp_strobe, !rsp_strobe)
   // a fix transfer never makes the block busy
   `ASSERT_NEXT(a_fix_one_cycle, clock, reset, start && !busy && req_item.func, !busy)
   // realigned results only after two fixes
   `ASSERT_IMPLY(a_est_needs_valid, clock, reset, rsp_strobe && rsp_item.estimated,
                 rsp_item.position_valid && rsp_item.enabled)

endmodule
